/* rtl/core/start_byte_length_deframer_core_defines.svh */
// ----------------------------------------------------------------------------
// start_byte_length_deframer_core_defines
// Assertion macros shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef START_BYTE_LENGTH_DEFRAMER_CORE_DEFINES_SVH
`define START_BYTE_LENGTH_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SBLD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define SBLD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sbld_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbld_pkg
// Types and constants of the start-byte, length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package sbld_pkg;

    localparam int unsigned LENGTH_BYTES = 4;
    localparam logic [7:0]  START_BYTE   = 8'hFF;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_LENGTH  = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_HEADER  = 2'd0,
        ROLE_LENGTH  = 2'd1,
        ROLE_PAYLOAD = 2'd2,
        ROLE_ABORT   = 2'd3
    } t_role;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] length_value;
        logic [1:0]  length_index;
        logic [31:0] bytes_remaining;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        t_role      role;
        logic       frame_end;
    } t_result;

endpackage

/* rtl/core/sbld_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbld_step
// Parser step: next state and optional result item for one received byte.
// ----------------------------------------------------------------------------
module sbld_step (
    input  sbld_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    output sbld_pkg::t_state  o_state,
    output sbld_pkg::t_result o_res
);

    logic [2:0]  w_idx_inc;
    logic        w_len_done;
    logic [31:0] w_len_next;
    logic [31:0] w_rem_dec;

    assign w_idx_inc  = {1'b0, i_state.length_index} + 3'd1;
    assign w_len_done = (w_idx_inc >= 3'(sbld_pkg::LENGTH_BYTES));
    assign w_len_next = i_state.length_value
                      | (32'(i_byte) << {i_state.length_index, 3'b000});
    // hold at zero rather than wrap
    assign w_rem_dec  = (i_state.bytes_remaining != 32'd0)
                      ? i_state.bytes_remaining - 32'd1 : 32'd0;

    always_comb begin
        o_state         = i_state;
        o_res.valid     = 1'b0;
        o_res.out_byte  = i_byte;
        o_res.role      = sbld_pkg::ROLE_HEADER;
        o_res.frame_end = 1'b0;

        priority if (i_byte == sbld_pkg::START_BYTE) begin
            // restart the frame; report an abort unless idle
            o_state.phase           = sbld_pkg::PH_HEADER;
            o_state.length_value    = 32'd0;
            o_state.length_index    = 2'd0;
            o_state.bytes_remaining = 32'd0;
            o_res.valid             = (i_state.phase != sbld_pkg::PH_IDLE);
            o_res.out_byte          = 8'd0;
            o_res.role              = sbld_pkg::ROLE_ABORT;
        end else begin
            unique case (i_state.phase)
                sbld_pkg::PH_IDLE: begin
                    // drop
                end
                sbld_pkg::PH_HEADER: begin
                    o_state.phase        = sbld_pkg::PH_LENGTH;
                    o_state.length_value = 32'd0;
                    o_state.length_index = 2'd0;
                    o_res.valid          = 1'b1;
                    o_res.role           = sbld_pkg::ROLE_HEADER;
                end
                sbld_pkg::PH_LENGTH: begin
                    o_res.valid          = 1'b1;
                    o_res.role           = sbld_pkg::ROLE_LENGTH;
                    o_state.length_value = w_len_next;
                    o_state.length_index = w_idx_inc[1:0];
                    if (w_len_done) begin
                        o_state.length_index = 2'd0;
                        if (w_len_next == 32'd0) begin
                            o_state.phase   = sbld_pkg::PH_IDLE;
                            o_res.frame_end = 1'b1;
                        end else begin
                            o_state.bytes_remaining = w_len_next;
                            o_state.phase           = sbld_pkg::PH_PAYLOAD;
                        end
                    end
                end
                sbld_pkg::PH_PAYLOAD: begin
                    o_res.valid             = 1'b1;
                    o_res.role              = sbld_pkg::ROLE_PAYLOAD;
                    o_state.bytes_remaining = w_rem_dec;
                    if (w_rem_dec == 32'd0) begin
                        o_state.phase   = sbld_pkg::PH_IDLE;
                        o_res.frame_end = 1'b1;
                    end
                end
                default: begin
                    o_state.phase = sbld_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/start_byte_length_deframer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_byte_length_deframer_core
// Splits a received byte stream into start-byte, length-prefixed frames and
// forwards each header, length and payload byte with a role tag, plus an abort item on restart.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  rx      | in        | i_rx_valid / o_rx_ready  | i_rx_byte
//  res     | out       | o_res_valid / i_res_ready| o_out_byte, o_role, o_frame_end
//
//  One item per cycle sustained while the result side accepts; a result is offered
//  once its item has passed the input register and then the result register.
//  The parse step sits between the two registers; the 32-bit length
//  assembly and remaining-count decrement set the path length.
//  Items that give no result retire without waiting for the result side.
//  Synchronous active-low reset empties both registers and returns to idle.
// ----------------------------------------------------------------------------
`include "start_byte_length_deframer_core_defines.svh"

module start_byte_length_deframer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_role,
    output logic       o_frame_end
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    sbld_pkg::t_state  r_state;
    sbld_pkg::t_state  n_state;
    sbld_pkg::t_result w_res;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    sbld_pkg::t_role   r_out_role;
    logic              r_out_frame_end;
    logic              w_advance;

    sbld_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_state (n_state),
        .o_res   (w_res)
    );

    // retire the staged item when its result (if any) has room
    assign w_advance  = r_in_valid && (!w_res.valid || !r_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid              <= 1'b0;
            r_out_valid             <= 1'b0;
            r_state.phase           <= sbld_pkg::PH_IDLE;
            r_state.length_value    <= 32'd0;
            r_state.length_index    <= 2'd0;
            r_state.bytes_remaining <= 32'd0;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (w_advance) begin
                r_state <= n_state;
            end
            if (w_advance && w_res.valid) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_advance && w_res.valid) begin
            r_out_byte      <= w_res.out_byte;
            r_out_role      <= w_res.role;
            r_out_frame_end <= w_res.frame_end;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_role      = r_out_role;
    assign o_frame_end = r_out_frame_end;

    `SBLD_ASSERT_IMP(a_abort_clean, i_clk, i_rst_n, r_out_valid && (r_out_role == sbld_pkg::ROLE_ABORT), !r_out_frame_end && (r_out_byte == 8'd0), "abort item carries data or frame end")
    `SBLD_ASSERT_IMP(a_payload_count, i_clk, i_rst_n, r_state.phase == sbld_pkg::PH_PAYLOAD, r_state.bytes_remaining != 32'd0, "payload phase with nothing remaining")
    `SBLD_ASSERT_IMP(a_idle_index, i_clk, i_rst_n, r_state.phase == sbld_pkg::PH_IDLE, r_state.length_index == 2'd0, "length index left over in idle")
    `SBLD_ASSERT_NXT(a_end_to_idle, i_clk, i_rst_n, w_advance && w_res.valid && w_res.frame_end, r_state.phase == sbld_pkg::PH_IDLE, "frame end did not return to idle")

endmodule
